@@ rtl/lz_copy_fill_decompressor_unit_assert.svh @@
// Assertion macros for the copy/fill decompressor.
// Used by the top level only.
`ifndef LZ_COPY_FILL_DECOMPRESSOR_UNIT_ASSERT_SVH
`define LZ_COPY_FILL_DECOMPRESSOR_UNIT_ASSERT_SVH
// implication checked on every clock edge outside reset
`define LZC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define LZC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ rtl/lzc_pkg.sv @@
// Shared types and constants for the copy/fill decompressor.
// No dependencies.
package lzc_pkg;
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_FEED  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] ST_MORE  = 2'd0;
  localparam logic [1:0] ST_OK    = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;
  localparam logic [1:0] ST_BAD   = 2'd3;

  localparam logic [2:0] PH_CMD   = 3'd0;
  localparam logic [2:0] PH_LIT   = 3'd1;
  localparam logic [2:0] PH_OFFLO = 3'd2;
  localparam logic [2:0] PH_OFFHI = 3'd3;
  localparam logic [2:0] PH_LENLO = 3'd4;
  localparam logic [2:0] PH_LENHI = 3'd5;
  localparam logic [2:0] PH_FILL  = 3'd6;

  localparam logic [7:0] LIT_CODE = 8'h80;

  // datapath operations
  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_CLEAR = 3'd1; // sweep store to zero
  localparam logic [2:0] OP_WLIT  = 3'd2; // write one byte of input
  localparam logic [2:0] OP_FILL  = 3'd3; // repeat byte
  localparam logic [2:0] OP_COPY  = 3'd4; // copy from src
  localparam logic [2:0] OP_READ  = 3'd5; // read one byte

  typedef struct packed {
    logic [2:0]  op;
    logic        go;
    logic [7:0]  val;
    logic [16:0] src;   // start source address (absolute)
    logic [16:0] count; // bytes to move
  } lzc_cmd_t;

  typedef struct packed {
    logic        busy;
    logic [7:0]  rdata;
  } lzc_stat_t;
endpackage

@@ rtl/lzc_datapath.sv @@
// Datapath: output store, write pointer and byte mover.
// Depends on lzc_pkg.
module lzc_datapath #(
  parameter int OUT_DEPTH = 65536
) (
  input  logic             clk,
  input  logic             rst_n,
  input  lzc_pkg::lzc_cmd_t cmd,
  input  logic [16:0]      frame_len,
  input  logic             wp_clr,
  output logic [16:0]      write_pos,
  output lzc_pkg::lzc_stat_t stat
);
  localparam int AW = $clog2(OUT_DEPTH);

  logic [7:0]  mem [OUT_DEPTH];
  logic [16:0] wp_r, wp_nxt;
  logic [16:0] src_r, src_nxt;
  logic [16:0] cnt_r, cnt_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [7:0]  val_r, val_nxt;
  logic [7:0]  rd_r;
  logic        rd_pend_r, rd_pend_nxt;
  logic        we;
  logic [AW-1:0] waddr;
  logic [7:0]  wdata;

  // copy: each byte is read from the source, then written at the write pointer
  always_comb begin
    wp_nxt = wp_r; src_nxt = src_r; cnt_nxt = cnt_r; op_nxt = op_r;
    val_nxt = val_r; rd_pend_nxt = 1'b0;
    we = 1'b0; waddr = wp_r[AW-1:0]; wdata = val_r;
    if (wp_clr) wp_nxt = '0;
    if (cmd.go) begin
      op_nxt = cmd.op; src_nxt = cmd.src; cnt_nxt = cmd.count; val_nxt = cmd.val;
      if (cmd.op == lzc_pkg::OP_READ) begin
        op_nxt = lzc_pkg::OP_NONE;
      end
    end else begin
      case (op_r)
        lzc_pkg::OP_CLEAR: begin
          we = 1'b1; waddr = src_r[AW-1:0]; wdata = '0;
          src_nxt = src_r + 17'd1;
          if (src_r == 17'(OUT_DEPTH - 1)) op_nxt = lzc_pkg::OP_NONE;
        end
        lzc_pkg::OP_WLIT, lzc_pkg::OP_FILL: begin
          if (cnt_r == '0 || wp_r >= frame_len) begin
            op_nxt = lzc_pkg::OP_NONE;
          end else begin
            we = 1'b1; wp_nxt = wp_r + 17'd1; cnt_nxt = cnt_r - 17'd1;
          end
        end
        lzc_pkg::OP_COPY: begin
          if (cnt_r == '0 || wp_r >= frame_len) begin
            op_nxt = lzc_pkg::OP_NONE;
          end else if (!rd_pend_r) begin
            rd_pend_nxt = 1'b1;
          end else begin
            we = 1'b1; wdata = rd_r; wp_nxt = wp_r + 17'd1;
            cnt_nxt = cnt_r - 17'd1;
            // source wraps at the end of the store
            src_nxt = (src_r == 17'(OUT_DEPTH - 1)) ? '0 : src_r + 17'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.go) rd_r <= mem[cmd.src[AW-1:0]];
    else rd_r <= mem[src_r[AW-1:0]];
  end

  // sweep the store to zero right after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; op_r <= lzc_pkg::OP_CLEAR; rd_pend_r <= 1'b0;
      src_r <= '0; cnt_r <= '0; val_r <= '0;
    end else begin
      wp_r <= wp_nxt; op_r <= op_nxt; rd_pend_r <= rd_pend_nxt;
      src_r <= src_nxt; cnt_r <= cnt_nxt; val_r <= val_nxt;
    end
  end

  assign write_pos  = wp_r;
  assign stat.busy  = (op_r != lzc_pkg::OP_NONE);
  assign stat.rdata = rd_r;
endmodule

@@ rtl/lzc_ctrl.sv @@
// Controller: command parser and handshake sequencing.
// Depends on lzc_pkg; drives lzc_datapath.
module lzc_ctrl #(
  parameter int OUT_DEPTH = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic [1:0]        in_cmd,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic [15:0]       in_addr,
  input  logic [16:0]       frame_len,
  input  logic [16:0]       write_pos,
  input  lzc_pkg::lzc_stat_t stat,
  input  logic              out_taken,
  output logic              in_ready,
  output lzc_pkg::lzc_cmd_t dp_cmd,
  output logic              wp_clr,
  output logic              res_valid,
  output logic [1:0]        res_status,
  output logic [7:0]        res_rdata
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WAIT = 2'd1; // datapath working
  localparam logic [1:0] S_SETL = 2'd2; // settle before finishing
  localparam logic [1:0] S_OUT  = 2'd3; // result pending

  logic [1:0]  state_r, state_nxt;
  logic [2:0]  ph_r, ph_nxt;
  logic [7:0]  hc_r, hc_nxt;
  logic [15:0] ho_r, ho_nxt;
  logic [7:0]  hl_r, hl_nxt;
  logic [1:0]  fs_r, fs_nxt;
  logic        lastp_r, lastp_nxt;
  logic        rdsel_r, rdsel_nxt;
  logic [1:0]  ty;
  logic        complete;
  logic [16:0] scount;
  logic [15:0] len16;

  assign ty = hc_r[7:6];
  assign scount = 17'(hc_r[5:0]) + 17'd3;
  assign len16 = {in_byte, hl_r};

  always_comb begin
    state_nxt = state_r; ph_nxt = ph_r; hc_nxt = hc_r; ho_nxt = ho_r; hl_nxt = hl_r;
    fs_nxt = fs_r; lastp_nxt = lastp_r; rdsel_nxt = rdsel_r;
    dp_cmd = '0; wp_clr = 1'b0; complete = 1'b0;
    unique case (state_r)
      S_IDLE: if (in_fire) begin
        rdsel_nxt = 1'b0; lastp_nxt = 1'b0;
        state_nxt = S_OUT;
        case (in_cmd)
          lzc_pkg::CMD_START: begin
            wp_clr = 1'b1; ph_nxt = lzc_pkg::PH_CMD; hc_nxt = '0; ho_nxt = '0;
            hl_nxt = '0;
            fs_nxt = (frame_len == '0) ? lzc_pkg::ST_OK : lzc_pkg::ST_MORE;
            dp_cmd.go = 1'b1; dp_cmd.op = lzc_pkg::OP_CLEAR;
            state_nxt = S_WAIT;
          end
          lzc_pkg::CMD_READ: begin
            rdsel_nxt = 1'b1;
            if (32'(in_addr) < OUT_DEPTH) begin
              dp_cmd.go = 1'b1; dp_cmd.op = lzc_pkg::OP_READ;
              dp_cmd.src = 17'(in_addr);
              state_nxt = S_SETL;
            end else rdsel_nxt = 1'b0;
          end
          lzc_pkg::CMD_FEED: if (fs_r == lzc_pkg::ST_MORE) begin
            unique case (ph_r)
              lzc_pkg::PH_CMD: begin
                if (write_pos >= frame_len) fs_nxt = lzc_pkg::ST_OK;
                else begin
                  hc_nxt = in_byte; ho_nxt = '0; hl_nxt = '0;
                  if (in_byte == lzc_pkg::LIT_CODE) ph_nxt = lzc_pkg::PH_LIT;
                  else if (in_byte[7:6] == 2'd3) ph_nxt = lzc_pkg::PH_FILL;
                  else ph_nxt = lzc_pkg::PH_OFFLO;
                  if (in_last) fs_nxt = lzc_pkg::ST_TRUNC;
                end
              end
              lzc_pkg::PH_LIT: begin
                dp_cmd.go = 1'b1; dp_cmd.op = lzc_pkg::OP_WLIT; dp_cmd.val = in_byte;
                dp_cmd.count = 17'd1; complete = 1'b1;
              end
              lzc_pkg::PH_FILL: begin
                dp_cmd.go = 1'b1; dp_cmd.op = lzc_pkg::OP_FILL; dp_cmd.val = in_byte;
                dp_cmd.count = scount; complete = 1'b1;
              end
              lzc_pkg::PH_OFFLO: begin
                ho_nxt = {8'd0, in_byte};
                if (ty == 2'd1) begin
                  complete = 1'b1;
                  if (in_byte == '0 || 17'(in_byte) > write_pos) fs_nxt = lzc_pkg::ST_BAD;
                  else begin
                    dp_cmd.go = 1'b1; dp_cmd.op = lzc_pkg::OP_COPY;
                    dp_cmd.src = write_pos - 17'(in_byte); dp_cmd.count = scount;
                  end
                end else begin
                  ph_nxt = lzc_pkg::PH_OFFHI;
                  if (in_last) fs_nxt = lzc_pkg::ST_TRUNC;
                end
              end
              lzc_pkg::PH_OFFHI: begin
                ho_nxt = {in_byte, ho_r[7:0]};
                if (ty == 2'd0) begin
                  complete = 1'b1;
                  if ({in_byte, ho_r[7:0]} == '0 ||
                      17'({in_byte, ho_r[7:0]}) > write_pos) fs_nxt = lzc_pkg::ST_BAD;
                  else begin
                    dp_cmd.go = 1'b1; dp_cmd.op = lzc_pkg::OP_COPY;
                    dp_cmd.src = write_pos - 17'({in_byte, ho_r[7:0]});
                    dp_cmd.count = scount;
                  end
                end else begin
                  ph_nxt = lzc_pkg::PH_LENLO;
                  if (in_last) fs_nxt = lzc_pkg::ST_TRUNC;
                end
              end
              lzc_pkg::PH_LENLO: begin
                hl_nxt = in_byte; ph_nxt = lzc_pkg::PH_LENHI;
                if (in_last) fs_nxt = lzc_pkg::ST_TRUNC;
              end
              lzc_pkg::PH_LENHI: begin
                complete = 1'b1;
                if (17'(ho_r) >= frame_len) fs_nxt = lzc_pkg::ST_BAD;
                else begin
                  dp_cmd.go = 1'b1; dp_cmd.op = lzc_pkg::OP_COPY;
                  dp_cmd.src = 17'(ho_r);
                  dp_cmd.count = (len16 != '0) ? 17'(len16) : scount;
                end
              end
              default: ph_nxt = lzc_pkg::PH_CMD;
            endcase
            if (complete) begin
              ph_nxt = lzc_pkg::PH_CMD;
              lastp_nxt = in_last;
              state_nxt = S_WAIT;
            end
          end
          default: ;
        endcase
      end
      S_WAIT: if (!stat.busy && !dp_cmd.go) state_nxt = S_SETL;
      S_SETL: begin
        // finish status once the write pointer has settled
        if (fs_r == lzc_pkg::ST_MORE && lastp_r) fs_nxt = lzc_pkg::ST_OK;
        state_nxt = S_OUT;
      end
      S_OUT: if (out_taken) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // wait_first_r holds S_WAIT on its entry before busy is checked
  logic wait_first_r;
  logic compl_r;
  logic fill_done;
  assign fill_done = (state_r == S_SETL) && (fs_r == lzc_pkg::ST_MORE) && !rdsel_r &&
                     (write_pos >= frame_len) && compl_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; ph_r <= lzc_pkg::PH_CMD; hc_r <= '0; ho_r <= '0; hl_r <= '0;
      fs_r <= lzc_pkg::ST_MORE; lastp_r <= 1'b0; rdsel_r <= 1'b0; wait_first_r <= 1'b0;
      compl_r <= 1'b0;
    end else begin
      state_r <= (state_r == S_WAIT && wait_first_r) ? S_WAIT : state_nxt;
      ph_r <= ph_nxt; hc_r <= hc_nxt; ho_r <= ho_nxt; hl_r <= hl_nxt;
      fs_r <= fill_done ? lzc_pkg::ST_OK : fs_nxt;
      lastp_r <= lastp_nxt; rdsel_r <= rdsel_nxt;
      wait_first_r <= (state_r == S_IDLE) && (state_nxt == S_WAIT);
      if (state_r == S_IDLE && in_fire) compl_r <= complete;
    end
  end

  // hold the input while the datapath is busy, as while the store is swept after reset
  assign in_ready   = (state_r == S_IDLE) && !stat.busy;
  assign res_valid  = (state_r == S_OUT);
  assign res_status = fs_r;
  assign res_rdata  = rdsel_r ? stat.rdata : 8'd0;
endmodule

@@ rtl/lz_copy_fill_decompressor_unit.sv @@
// Top level of the copy/fill decompressor: controller plus datapath.
// Depends on lzc_pkg, lzc_ctrl, lzc_datapath and the assertion header.
//
// channel | dir | tdata fields (low bit first)          | tuser
// in      | in  | cmd[1:0] data_byte[9:2] read_addr[25:10] | -, tlast = last_byte
// out     | out | status[1:0] written_count[18:2] read_data[26:19] | -
// cfg     | in  | output_length[16:0]                     | -
//
// Each input transfer gets one result; a byte that finishes a command waits for the
// datapath to write its literal, fill or copied bytes, and the single-port store sets
// the copy rate. A start sweeps the whole store. Reset is synchronous; after reset the
// same sweep runs before the first input transfer.
// One item is in flight at a time; a stalled result holds the input.
module lz_copy_fill_decompressor_unit #(
  parameter int OUT_DEPTH = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,  // cmd, data_byte, read_addr, zero pad
  input  logic        in_tlast,  // last_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata, // status, written_count, read_data, zero pad
  input  logic        cfg_we,
  input  logic [16:0] cfg_wdata  // output_length
);
  logic [16:0] olen_r;
  logic [16:0] frame_len;
  logic [16:0] write_pos;
  logic        in_fire;
  logic        wp_clr;
  logic [1:0]  res_status;
  logic [7:0]  res_rdata;
  lzc_pkg::lzc_cmd_t  dp_cmd;
  lzc_pkg::lzc_stat_t stat;

  always_ff @(posedge clk) begin
    if (!rst_n) olen_r <= 17'h10000;
    else if (cfg_we) olen_r <= cfg_wdata;
  end

  assign frame_len = (32'(olen_r) > OUT_DEPTH) ? 17'(OUT_DEPTH) : olen_r;
  assign in_fire = in_tvalid && in_tready;

  lzc_ctrl #(.OUT_DEPTH(OUT_DEPTH)) u_ctrl (
    .clk, .rst_n, .in_fire,
    .in_cmd(in_tdata[1:0]), .in_byte(in_tdata[9:2]), .in_last(in_tlast),
    .in_addr(in_tdata[25:10]), .frame_len, .write_pos, .stat,
    .out_taken(out_tready), .in_ready(in_tready), .dp_cmd, .wp_clr,
    .res_valid(out_tvalid), .res_status, .res_rdata
  );

  lzc_datapath #(.OUT_DEPTH(OUT_DEPTH)) u_dp (
    .clk, .rst_n, .cmd(dp_cmd), .frame_len, .wp_clr, .write_pos, .stat
  );

  assign out_tdata = {5'd0, res_rdata, write_pos, res_status};

  `include "lz_copy_fill_decompressor_unit_assert.svh"
  `LZC_ASSERT_IMPL(a_wp_bound, 1'b1, write_pos <= 17'(OUT_DEPTH))
  `LZC_ASSERT_IMPL(a_no_accept_busy, stat.busy, !in_tready)
  `LZC_ASSERT_NEXT(a_hold_result, out_tvalid && !out_tready, out_tvalid)
endmodule
